// ----- sv/he_pkg.sv -----
// Shared types and constants for the histogram equalizer.
// Used by he_alu, he_bin_ram and histogram_equalizer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package he_pkg;

    localparam int unsigned MAX_PIXELS = 65536;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned BIN_N      = 1 << PIX_W;
    localparam int unsigned ADDR_W     = PIX_W;
    localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int unsigned DIV_W      = CNT_W + PIX_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [PIX_W-1:0] EQ_MAX = {PIX_W{1'b1}};

    typedef enum logic
    {
        ALU_ADD_SAT,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t          op;
        logic [DIV_W-1:0] a;
        logic [DIV_W-1:0] b;
    } alu_req_t;

    typedef struct packed
    {
        logic [DIV_W-1:0] res;
        logic             borrow;
    } alu_rsp_t;

    typedef struct packed
    {
        logic              re;
        logic              we;
        logic              clr;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  wdata;
    } ram_req_t;

endpackage

`default_nettype wire

// ----- sv/histogram_equalizer.sv -----
// Two-pass 8-bit histogram equalizer: sequencer around one shared ALU and the bin memory.
// Depends on he_pkg, he_alu and he_bin_ram.
// A count transaction reads its bin and writes it back plus one; the last one adds a walk that
// turns the bins into a cumulative histogram. A map transaction runs bin read, multiply,
// 25 divide steps and output; with no cumulative histogram it goes straight to output with zero.
// A stalled result holds the output state. Reset clears all bin valid bits at once.
`timescale 1ns / 1ps
`default_nettype none

module histogram_equalizer
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] pixel
    input  wire        s_axis_tuser,   // [0] cmd
    input  wire        s_axis_tlast,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] equalized
    output logic       m_axis_tlast
);
    import he_pkg::*;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_CNT_RD,
        S_CNT_WR,
        S_CUM_RD,
        S_CUM_WR,
        S_MAP_RD,
        S_MAP_MUL,
        S_DIV,
        S_OUT
    } state_t;

    state_t               state_reg,     state_next;
    logic [PIX_W-1:0]     pix_reg,       pix_next;
    logic                 last_reg,      last_next;
    logic [CNT_W-1:0]     total_reg,     total_next;
    logic                 ready_reg,     ready_next;
    logic [CNT_W-1:0]     run_reg,       run_next;
    logic [ADDR_W-1:0]    k_reg,         k_next;
    logic [CNT_W-1:0]     rem_reg,       rem_next;
    logic [DIV_W-1:0]     quo_reg,       quo_next;
    logic [DIV_CNT_W-1:0] step_reg,      step_next;
    logic [PIX_W-1:0]     eq_reg,        eq_next;
    logic                 m_valid_reg,   m_valid_next;
    logic [PIX_W-1:0]     m_data_reg,    m_data_next;
    logic                 m_last_reg,    m_last_next;

    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;
    ram_req_t         ram_req;
    logic [CNT_W-1:0] ram_rdata;
    logic [CNT_W:0]   shifted;
    logic             in_fire;

    he_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    he_bin_ram u_ram
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign shifted       = {rem_reg, quo_reg[DIV_W-1]};

    always_comb
    begin
        state_next   = state_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        total_next   = total_reg;
        ready_next   = ready_reg;
        run_next     = run_reg;
        k_next       = k_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        eq_next      = eq_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        alu_req.op = ALU_ADD_SAT;
        alu_req.a  = '0;
        alu_req.b  = '0;

        ram_req.re    = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.clr   = 1'b0;
        ram_req.addr  = pix_reg;
        ram_req.wdata = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pix_next  = s_axis_tdata;
                    last_next = s_axis_tlast;
                    if (!s_axis_tuser)
                    begin
                        if (!ready_reg)
                        begin
                            state_next = S_CNT_RD;
                        end
                    end
                    else if (!ready_reg)
                    begin
                        eq_next    = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MAP_RD;
                    end
                end
            end
            S_CNT_RD:
            begin
                ram_req.re = 1'b1;
                alu_req.a  = {{PIX_W{1'b0}}, total_reg};
                alu_req.b  = DIV_W'(1);
                total_next = alu_rsp.res[CNT_W-1:0];
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                alu_req.a     = {{PIX_W{1'b0}}, ram_rdata};
                alu_req.b     = DIV_W'(1);
                ram_req.we    = 1'b1;
                ram_req.wdata = alu_rsp.res[CNT_W-1:0];
                if (last_reg)
                begin
                    k_next     = '0;
                    run_next   = '0;
                    state_next = S_CUM_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CUM_RD:
            begin
                ram_req.re   = 1'b1;
                ram_req.addr = k_reg;
                state_next   = S_CUM_WR;
            end
            S_CUM_WR:
            begin
                alu_req.a     = {{PIX_W{1'b0}}, run_reg};
                alu_req.b     = {{PIX_W{1'b0}}, ram_rdata};
                ram_req.we    = 1'b1;
                ram_req.addr  = k_reg;
                ram_req.wdata = alu_rsp.res[CNT_W-1:0];
                run_next      = alu_rsp.res[CNT_W-1:0];
                if (k_reg == ADDR_W'(BIN_N - 1))
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CUM_RD;
                end
            end
            S_MAP_RD:
            begin
                ram_req.re = 1'b1;
                state_next = S_MAP_MUL;
            end
            S_MAP_MUL:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {ram_rdata, {PIX_W{1'b0}}};
                alu_req.b  = {{PIX_W{1'b0}}, ram_rdata};
                if (total_reg == '0)
                begin
                    eq_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    quo_next   = alu_rsp.res;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(DIV_W - CNT_W - 1){1'b0}}, shifted};
                alu_req.b  = {{PIX_W{1'b0}}, total_reg};
                if (alu_rsp.borrow)
                begin
                    rem_next = shifted[CNT_W-1:0];
                end
                else
                begin
                    rem_next = alu_rsp.res[CNT_W-1:0];
                end
                quo_next  = {quo_reg[DIV_W-2:0], !alu_rsp.borrow};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    if (|quo_next[DIV_W-1:PIX_W])
                    begin
                        eq_next = EQ_MAX;
                    end
                    else
                    begin
                        eq_next = quo_next[PIX_W-1:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = eq_reg;
                    m_last_next  = last_reg;
                    if (last_reg && ready_reg)
                    begin
                        ram_req.clr = 1'b1;
                        total_next  = '0;
                        ready_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pix_reg     <= '0;
            last_reg    <= 1'b0;
            total_reg   <= '0;
            ready_reg   <= 1'b0;
            run_reg     <= '0;
            k_reg       <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            step_reg    <= '0;
            eq_reg      <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pix_reg     <= pix_next;
            last_reg    <= last_next;
            total_reg   <= total_next;
            ready_reg   <= ready_next;
            run_reg     <= run_next;
            k_reg       <= k_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            step_reg    <= step_next;
            eq_reg      <= eq_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_last_reg  <= m_last_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/he_alu.sv -----
// Shared arithmetic unit: saturating add and subtract with borrow.
// Depends on he_pkg.
`timescale 1ns / 1ps
`default_nettype none

module he_alu
(
    input  he_pkg::alu_req_t req,
    output he_pkg::alu_rsp_t rsp
);
    import he_pkg::*;

    localparam logic [DIV_W:0] MAX_WIDE = (DIV_W + 1)'(MAX_PIXELS);

    logic [DIV_W:0] sum;
    logic [DIV_W:0] diff;

    always_comb
    begin
        sum  = {1'b0, req.a} + {1'b0, req.b};
        diff = {1'b0, req.a} - {1'b0, req.b};
        rsp.borrow = diff[DIV_W];
        case (req.op)
            ALU_ADD_SAT:
            begin
                if (sum > MAX_WIDE)
                begin
                    rsp.res = MAX_WIDE[DIV_W-1:0];
                end
                else
                begin
                    rsp.res = sum[DIV_W-1:0];
                end
            end
            ALU_SUB:
            begin
                rsp.res = diff[DIV_W-1:0];
            end
            default:
            begin
                rsp.res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/he_bin_ram.sv -----
// Histogram bin memory with one port, registered read and per-entry valid bits.
// An entry that is not valid reads as zero. Depends on he_pkg.
`timescale 1ns / 1ps
`default_nettype none

module he_bin_ram
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  he_pkg::ram_req_t         req,
    output logic [he_pkg::CNT_W-1:0] rdata
);
    import he_pkg::*;

    logic [CNT_W-1:0] mem [BIN_N];
    logic [BIN_N-1:0] valid_reg;
    logic [CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= valid_reg[req.addr] ? mem[req.addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clr)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
